// ===== design/uss_pkg.sv =====
// Shared types, codes and coil tables for the unipolar stepper sequencer.
`timescale 1ns / 1ps
`default_nettype none

package uss_pkg;

    localparam int CountW  = 32;
    localparam int StepsW  = 31;
    localparam int PosW    = 16;
    localparam int PeriodW = 10;
    localparam int CoilW   = 4;
    localparam int FuncW   = 2;
    localparam int OutW    = 24;
    localparam int AddrW   = 4;
    localparam int DataW   = 32;

    localparam logic [FuncW-1:0] FUNC_TICK = 2'd0;
    localparam logic [FuncW-1:0] FUNC_MOVE = 2'd1;
    localparam logic [FuncW-1:0] FUNC_STOP = 2'd2;

    localparam logic [1:0] REG_HALF_STEP = 2'd0;
    localparam logic [1:0] REG_PERIOD    = 2'd1;
    localparam logic [1:0] REG_TURN      = 2'd2;
    localparam logic [1:0] REG_ECO       = 2'd3;

    localparam logic [PeriodW-1:0] PERIOD_RESET = 10'd1000;
    localparam logic [PosW-1:0]    TURN_RESET   = 16'd200;
    localparam logic [StepsW-1:0]  STEPS_MAX    = {StepsW{1'b1}};

    typedef struct packed {
        logic [StepsW-1:0]  steps_remaining;
        logic               direction_up;
        logic [PosW-1:0]    step_position;
        logic [PeriodW-1:0] wait_ticks;
        logic               eco_powered_off;
        logic [CoilW-1:0]   coil_latch;
    } motor_state_t;

    typedef struct packed {
        logic               half_step_mode;
        logic [PeriodW-1:0] step_period_ms;
        logic [PosW-1:0]    steps_per_turn;
        logic               eco_enable;
    } motor_cfg_t;

    function automatic logic [CoilW-1:0] coil_lookup(input logic half, input logic [2:0] ph);
        logic [CoilW-1:0] pat;
        if (half)
        begin
            case (ph)
                3'd0:    pat = 4'd1;
                3'd1:    pat = 4'd3;
                3'd2:    pat = 4'd2;
                3'd3:    pat = 4'd6;
                3'd4:    pat = 4'd4;
                3'd5:    pat = 4'd12;
                3'd6:    pat = 4'd8;
                default: pat = 4'd9;
            endcase
        end
        else
        begin
            case (ph[1:0])
                2'd0:    pat = 4'd1;
                2'd1:    pat = 4'd2;
                2'd2:    pat = 4'd4;
                default: pat = 4'd8;
            endcase
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== design/unipolar_stepper_sequencer.sv =====
// Top level of the unipolar stepper sequencer: stream ports, registers, request pipeline.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata step_count, s_tuser func
//   m_*     | out | m_tvalid/m_tready  | m_tdata coil_pattern, coil_update, busy_res, position
//   apb     | in  | psel/penable/pready| paddr, pwdata, prdata
//
// One request per clock unless m_tready stalls; a request's result passes through the
// input register, then the result register. Motor state updates in the input-to-result
// step, so back-to-back requests see each other's effects. An m_tready stall holds the
// result and backs up into the input register before s_tready drops.
// Reset clears the motor state, the pipeline valids and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module unipolar_stepper_sequencer
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [uss_pkg::CountW-1:0]    s_tdata,   // [31:0] step_count
    input  wire [uss_pkg::FuncW-1:0]     s_tuser,   // [1:0] func
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [uss_pkg::OutW-1:0]     m_tdata,   // [3:0] coil_pattern, [4] coil_update,
                                                    // [5] busy_res, [21:6] position, [23:22] 0
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [uss_pkg::AddrW-1:0]     paddr,
    input  wire [uss_pkg::DataW-1:0]     pwdata,
    output logic [uss_pkg::DataW-1:0]    prdata,
    output logic                         pready
);

    uss_pkg::motor_cfg_t   cfg_reg;
    uss_pkg::motor_state_t st_reg;
    uss_pkg::motor_state_t st_next;

    logic                       in_valid_reg;
    logic [uss_pkg::FuncW-1:0]  in_func_reg;
    logic [uss_pkg::CountW-1:0] in_count_reg;
    logic                       out_valid_reg;
    logic [uss_pkg::OutW-1:0]   out_data_reg;
    logic                       coil_update;
    logic                       advance;
    logic                       take;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_step_mode <= 1'b0;
            cfg_reg.step_period_ms <= uss_pkg::PERIOD_RESET;
            cfg_reg.steps_per_turn <= uss_pkg::TURN_RESET;
            cfg_reg.eco_enable     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                uss_pkg::REG_HALF_STEP: cfg_reg.half_step_mode <= pwdata[0];
                uss_pkg::REG_PERIOD:    cfg_reg.step_period_ms <= pwdata[uss_pkg::PeriodW-1:0];
                uss_pkg::REG_TURN:      cfg_reg.steps_per_turn <= pwdata[uss_pkg::PosW-1:0];
                uss_pkg::REG_ECO:       cfg_reg.eco_enable     <= pwdata[0];
                default:                cfg_reg.eco_enable     <= cfg_reg.eco_enable;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            uss_pkg::REG_HALF_STEP: prdata[0]                    = cfg_reg.half_step_mode;
            uss_pkg::REG_PERIOD:    prdata[uss_pkg::PeriodW-1:0] = cfg_reg.step_period_ms;
            uss_pkg::REG_TURN:      prdata[uss_pkg::PosW-1:0]    = cfg_reg.steps_per_turn;
            uss_pkg::REG_ECO:       prdata[0]                    = cfg_reg.eco_enable;
            default:                prdata                       = '0;
        endcase
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_func_reg  <= s_tuser;
            in_count_reg <= s_tdata;
        end
    end

    uss_step u_step
    (
        .cur         (st_reg),
        .cfg         (cfg_reg),
        .func        (in_func_reg),
        .step_count  (in_count_reg),
        .nxt         (st_next),
        .coil_update (coil_update)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st_reg        <= st_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {2'b00, st_next.step_position, (st_next.steps_remaining != '0),
                             coil_update, st_next.coil_latch};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/uss_step.sv =====
// Next-state and result logic for one tick, move or stop request.
`timescale 1ns / 1ps
`default_nettype none

module uss_step
(
    input  wire uss_pkg::motor_state_t        cur,
    input  wire uss_pkg::motor_cfg_t          cfg,
    input  wire [uss_pkg::FuncW-1:0]          func,
    input  wire [uss_pkg::CountW-1:0]         step_count,
    output uss_pkg::motor_state_t             nxt,
    output logic                              coil_update
);

    logic [uss_pkg::PosW:0]     pos_inc;
    logic [uss_pkg::PosW-1:0]   pos_step;
    logic [uss_pkg::CountW-1:0] count_neg;
    logic [uss_pkg::StepsW-1:0] mag;
    logic                       do_step;
    logic                       busy;

    assign busy      = cur.steps_remaining != '0;
    assign do_step   = busy && (cur.wait_ticks == '0);
    assign pos_inc   = {1'b0, cur.step_position} + {{uss_pkg::PosW{1'b0}}, 1'b1};
    assign count_neg = ~step_count + 32'd1;

    always_comb
    begin
        if (cur.direction_up)
        begin
            pos_step = (pos_inc > {1'b0, cfg.steps_per_turn}) ? '0 : pos_inc[uss_pkg::PosW-1:0];
        end
        else
        begin
            pos_step = (cur.step_position == '0) ? cfg.steps_per_turn
                                                 : cur.step_position - 16'd1;
        end
    end

    always_comb
    begin
        if (step_count[uss_pkg::CountW-1])
        begin
            mag = count_neg[uss_pkg::CountW-1] ? uss_pkg::STEPS_MAX
                                               : count_neg[uss_pkg::StepsW-1:0];
        end
        else
        begin
            mag = step_count[uss_pkg::StepsW-1:0];
        end
    end

    always_comb
    begin
        nxt         = cur;
        coil_update = 1'b0;
        case (func)
            uss_pkg::FUNC_TICK:
            begin
                if (do_step)
                begin
                    nxt.step_position   = pos_step;
                    nxt.coil_latch      = uss_pkg::coil_lookup(cfg.half_step_mode, pos_step[2:0]);
                    nxt.steps_remaining = cur.steps_remaining - 31'd1;
                    nxt.wait_ticks      = cfg.step_period_ms;
                    coil_update         = 1'b1;
                end
                else if (cur.wait_ticks != '0)
                begin
                    nxt.wait_ticks = cur.wait_ticks - 10'd1;
                end
                if (cfg.eco_enable && !cur.eco_powered_off && (nxt.steps_remaining == '0))
                begin
                    nxt.eco_powered_off = 1'b1;
                    nxt.coil_latch      = '0;
                    coil_update         = 1'b1;
                end
            end
            uss_pkg::FUNC_MOVE:
            begin
                if (step_count[uss_pkg::CountW-1])
                begin
                    nxt.direction_up = 1'b0;
                end
                else if (step_count != '0)
                begin
                    nxt.direction_up = 1'b1;
                end
                nxt.steps_remaining = mag;
                if (cfg.eco_enable && cur.eco_powered_off)
                begin
                    nxt.coil_latch      = uss_pkg::coil_lookup(cfg.half_step_mode,
                                                               cur.step_position[2:0]);
                    nxt.eco_powered_off = 1'b0;
                    coil_update         = 1'b1;
                end
            end
            uss_pkg::FUNC_STOP:
            begin
                if (busy)
                begin
                    nxt.steps_remaining = '0;
                    if (cfg.eco_enable)
                    begin
                        nxt.coil_latch = '0;
                        coil_update    = 1'b1;
                    end
                end
            end
            default:
            begin
                coil_update = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/uss_checker.sv =====
// Port-level checks for the unipolar stepper sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module uss_checker
(
    input wire                       clk,
    input wire                       rst_n,
    input wire                       m_tvalid,
    input wire                       m_tready,
    input wire [uss_pkg::OutW-1:0]   m_tdata,
    input wire                       pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_coil_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(m_tdata[3:0]) <= 2))
        else $error("more than two coils driven");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:22] == 2'b00) && pready)
        else $error("result padding not zero or config port not ready");

endmodule

bind unipolar_stepper_sequencer uss_checker u_uss_checker (.*);

`default_nettype wire
